[rtl/tcw_pkg.sv]
// Package for the text console writer: request and response beat types,
// controller command struct and character constants.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    localparam int CELL_IDX_W = 11;
    localparam int CURSOR_W   = 11;

    localparam logic       OP_PUT       = 1'b0;
    localparam logic       OP_READ      = 1'b1;

    localparam logic [7:0] CHAR_NUL     = 8'd0;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] ATTR_DEFAULT = 8'd7;

    typedef struct packed {
        logic                  opcode;
        logic [7:0]            char_code;
        logic                  begin_line;
        logic                  end_of_string;
        logic [CELL_IDX_W-1:0] cell_index;
    } tcw_req_t;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_cell;
        logic [CURSOR_W-1:0] hw_cursor;
        logic                scrolled;
        logic [7:0]          read_char;
        logic [7:0]          read_attr;
    } tcw_rsp_t;

    typedef struct packed {
        logic load;
        logic put_commit;
        logic rd_mul;
        logic rd_fix;
        logic rd_mem;
        logic rd_commit;
    } tcw_cmd_t;

endpackage

`default_nettype wire

[rtl/text_console_writer.sv]
// Text console writer: a COLUMNS x ROWS text screen with a cursor. A put beat
// is accepted, then committed in an update state; a scroll costs nothing
// extra because rows live in a rotating map and a scrolled-in row is blanked by
// clearing its fill count. A read beat steps through the reciprocal multiply
// that splits the cell index into row and column, the multiply back, and the
// registered screen memory read. The screen is blank straight out of
// reset with no clearing pass. A new beat is taken once the previous one has
// reached the response register, even while that response waits to be taken.
// Depends on tcw_pkg, tcw_ctrl and tcw_dp.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire tcw_pkg::tcw_req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output tcw_pkg::tcw_rsp_t      rsp
);

    localparam int CELLS = COLUMNS * ROWS;

    tcw_pkg::tcw_cmd_t cmd;

    tcw_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_opcode (req.opcode),
        .rsp_ready  (rsp_ready),
        .req_ready  (req_ready),
        .rsp_valid  (rsp_valid),
        .cmd        (cmd)
    );

    tcw_dp
    #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    )
    u_dp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

    // One beat at a time: an accepted beat closes the request side.
    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while a beat was in progress");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (CELLS > 2047) || (rsp.cursor_cell <= 11'(CELLS)))
        else $error("cursor beyond end of screen");

    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.scrolled |->
            (CELLS > 2047) || (rsp.cursor_cell >= 11'(CELLS - COLUMNS)))
        else $error("cursor not on last row after scroll");

    a_scroll_put: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.scrolled |-> (rsp.read_char == 8'd0) && (rsp.read_attr == 8'd0))
        else $error("scroll reported on a read beat");

endmodule

`default_nettype wire

[rtl/tcw_ctrl.sv]
// Controller state machine for the text console writer.
// Sequences put and read beats and owns the response valid flag.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire logic              req_opcode,
    input  wire logic              rsp_ready,
    output logic                   req_ready,
    output logic                   rsp_valid,
    output tcw_pkg::tcw_cmd_t      cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PUT  = 3'd1;
    localparam logic [2:0] S_RMUL = 3'd2;
    localparam logic [2:0] S_RFIX = 3'd3;
    localparam logic [2:0] S_RMEM = 3'd4;
    localparam logic [2:0] S_ROUT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       slot_free;

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (req_opcode == tcw_pkg::OP_READ) ? S_RMUL : S_PUT;
                end
            end
            S_PUT:
            begin
                if (slot_free)
                begin
                    cmd.put_commit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_RMUL:
            begin
                cmd.rd_mul = 1'b1;
                state_next = S_RFIX;
            end
            S_RFIX:
            begin
                cmd.rd_fix = 1'b1;
                state_next = S_RMEM;
            end
            S_RMEM:
            begin
                cmd.rd_mem = 1'b1;
                state_next = S_ROUT;
            end
            S_ROUT:
            begin
                if (slot_free)
                begin
                    cmd.rd_commit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.put_commit || cmd.rd_commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire

[rtl/tcw_dp.sv]
// Datapath for the text console writer: cursor, rotating row map with per-row
// fill counts, screen memory, read address split and response register.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_dp
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tcw_pkg::tcw_cmd_t cmd,
    input  wire tcw_pkg::tcw_req_t req,
    output tcw_pkg::tcw_rsp_t      rsp
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int CW1   = CW + 1;
    localparam int RW    = $clog2(ROWS + 2);
    localparam int SW    = RW + 1;
    localparam int PRW   = $clog2(ROWS);
    localparam int CELLS = COLUMNS * ROWS;
    localparam int LW    = $clog2(CELLS + COLUMNS + 1);
    localparam int IW    = tcw_pkg::CELL_IDX_W;
    localparam int OW    = tcw_pkg::CURSOR_W;
    localparam int XW    = LW + OW;
    localparam int CMPW  = (LW > IW) ? LW : IW;
    localparam int SH    = IW + CW;
    localparam int MW    = SH + 1;
    localparam int PW    = IW + MW;
    localparam int QW    = IW;
    localparam int QCW   = IW + CW1;
    localparam int DEPTH = ROWS << CW;
    localparam int AW    = PRW + CW;
    localparam longint unsigned RECIP = ((64'd1 << SH) + COLUMNS - 1) / COLUMNS;

    tcw_pkg::tcw_req_t req_reg;
    tcw_pkg::tcw_rsp_t rsp_reg;
    tcw_pkg::tcw_rsp_t rsp_next;

    logic [RW-1:0]  row_reg;
    logic [RW-1:0]  row_next;
    logic [CW-1:0]  col_reg;
    logic [CW-1:0]  col_next;
    logic [LW-1:0]  lin_reg;
    logic [LW-1:0]  lin_next;
    logic [PRW-1:0] base_reg;
    logic [PRW-1:0] base_next;
    logic [LW-1:0]  hw_reg;
    logic [LW-1:0]  hw_next;
    logic [CW1-1:0] fill_reg [ROWS];
    logic [CW1-1:0] fill_next [ROWS];

    logic [15:0]    mem [DEPTH];

    logic [RW-1:0]  row_a, row_b, row_c, row_f;
    logic [CW1-1:0] col_a, col_b, col_c, col_f;
    logic [LW-1:0]  lin_a, lin_b, lin_c, lin_f;
    logic           nl;
    logic           wr_ch;
    logic           do_scroll;
    logic           do_write;
    logic [PRW-1:0] base_new;
    logic [SW-1:0]  phys_sum;
    logic [PRW-1:0] wr_phys;
    logic [AW-1:0]  wr_addr;

    logic [PW-1:0]  rd_prod_reg;
    logic [PRW-1:0] rd_row_reg;
    logic [CW-1:0]  rd_col_reg;
    logic           rd_ok_reg;
    logic           rd_hit_reg;
    logic [15:0]    rd_data_reg;
    logic [QW-1:0]  rd_q;
    logic [QCW-1:0] rd_qc;
    logic [IW-1:0]  rd_col_full;
    logic           rd_ok;
    logic [SW-1:0]  rd_sum;
    logic [PRW-1:0] rd_phys;
    logic [AW-1:0]  rd_addr;
    logic [7:0]     rd_char;
    logic [7:0]     rd_attr;

    logic [XW-1:0]  lin_x;
    logic [XW-1:0]  hw_x;

    // A put beat: optional row alignment, newline, scroll by rotating the row
    // map, then at most one cell write.
    always_comb
    begin
        nl    = (req_reg.char_code == tcw_pkg::CHAR_NEWLINE);
        wr_ch = !nl && (req_reg.char_code != tcw_pkg::CHAR_NUL);

        row_a = row_reg;
        col_a = CW1'(col_reg);
        lin_a = lin_reg;
        if (req_reg.begin_line && (col_reg != '0))
        begin
            row_a = row_reg + RW'(1);
            col_a = '0;
            lin_a = lin_reg + LW'(COLUMNS) - LW'(col_reg);
        end

        row_b = row_a;
        col_b = col_a;
        lin_b = lin_a;
        if (nl)
        begin
            row_b = row_a + RW'(1);
            col_b = '0;
            lin_b = lin_a + LW'(COLUMNS) - LW'(col_a);
        end

        do_scroll = (nl || wr_ch) && (row_b >= RW'(ROWS));
        row_c     = row_b;
        col_c     = col_b;
        lin_c     = lin_b;
        base_new  = base_reg;
        if (do_scroll)
        begin
            row_c    = row_b - RW'(1);
            lin_c    = lin_b - LW'(COLUMNS);
            base_new = (base_reg == PRW'(ROWS - 1)) ? '0 : base_reg + PRW'(1);
        end

        do_write = wr_ch && (row_c < RW'(ROWS));
        phys_sum = SW'(row_c) + SW'(base_new);
        if (phys_sum >= SW'(ROWS))
        begin
            phys_sum = phys_sum - SW'(ROWS);
        end
        wr_phys = phys_sum[PRW-1:0];
        wr_addr = {wr_phys, col_c[CW-1:0]};

        row_f = row_c;
        col_f = col_c;
        lin_f = lin_c;
        if (do_write)
        begin
            lin_f = lin_c + LW'(1);
            if (col_c == CW1'(COLUMNS - 1))
            begin
                row_f = row_c + RW'(1);
                col_f = '0;
            end
            else
            begin
                col_f = col_c + CW1'(1);
            end
        end
    end

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        lin_next  = lin_reg;
        base_next = base_reg;
        hw_next   = hw_reg;
        fill_next = fill_reg;
        if (cmd.put_commit)
        begin
            row_next  = row_f;
            col_next  = col_f[CW-1:0];
            lin_next  = lin_f;
            base_next = base_new;
            if (do_scroll)
            begin
                fill_next[base_reg] = '0;
            end
            if (do_write)
            begin
                fill_next[wr_phys] = col_c + CW1'(1);
            end
        end
        if ((cmd.put_commit || cmd.rd_commit) && req_reg.end_of_string)
        begin
            hw_next = lin_next;
        end
    end

    // Read address split: the row comes from an exact reciprocal multiply.
    assign rd_q        = rd_prod_reg[SH +: QW];
    assign rd_qc       = QCW'(rd_q) * QCW'(COLUMNS);
    assign rd_col_full = req_reg.cell_index - rd_qc[IW-1:0];
    assign rd_ok       = CMPW'(req_reg.cell_index) < CMPW'(CELLS);

    always_comb
    begin
        rd_sum = SW'(rd_row_reg) + SW'(base_reg);
        if (rd_sum >= SW'(ROWS))
        begin
            rd_sum = rd_sum - SW'(ROWS);
        end
        rd_phys = rd_sum[PRW-1:0];
        rd_addr = {rd_phys, rd_col_reg};
    end

    always_comb
    begin
        if (!rd_ok_reg)
        begin
            rd_char = 8'd0;
            rd_attr = 8'd0;
        end
        else if (rd_hit_reg)
        begin
            rd_char = rd_data_reg[7:0];
            rd_attr = rd_data_reg[15:8];
        end
        else
        begin
            rd_char = tcw_pkg::CHAR_SPACE;
            rd_attr = tcw_pkg::ATTR_DEFAULT;
        end
    end

    assign lin_x = {{OW{1'b0}}, lin_next};
    assign hw_x  = {{OW{1'b0}}, hw_next};

    always_comb
    begin
        rsp_next             = rsp_reg;
        rsp_next.cursor_cell = lin_x[OW-1:0];
        rsp_next.hw_cursor   = hw_x[OW-1:0];
        if (cmd.put_commit)
        begin
            rsp_next.scrolled  = do_scroll;
            rsp_next.read_char = 8'd0;
            rsp_next.read_attr = 8'd0;
        end
        else
        begin
            rsp_next.scrolled  = 1'b0;
            rsp_next.read_char = rd_char;
            rsp_next.read_attr = rd_attr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            lin_reg  <= '0;
            base_reg <= '0;
            hw_reg   <= '0;
            for (int i = 0; i < ROWS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            lin_reg  <= lin_next;
            base_reg <= base_next;
            hw_reg   <= hw_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.rd_mul)
        begin
            rd_prod_reg <= PW'(req_reg.cell_index) * PW'(RECIP);
        end
        if (cmd.rd_fix)
        begin
            rd_row_reg <= rd_q[PRW-1:0];
            rd_col_reg <= rd_col_full[CW-1:0];
            rd_ok_reg  <= rd_ok;
        end
        if (cmd.rd_mem)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_hit_reg  <= rd_ok_reg && (CW1'(rd_col_reg) < fill_reg[rd_phys]);
        end
        if (cmd.put_commit && do_write)
        begin
            mem[wr_addr] <= {tcw_pkg::ATTR_DEFAULT, req_reg.char_code};
        end
        if (cmd.put_commit || cmd.rd_commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Testbench for text_console_writer: random and directed put and read beats,
// checked against a screen, cursor and hardware cursor model kept here.
// Depends on tcw_pkg and the text_console_writer RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int COLS        = 80;
    localparam int ROWS        = 25;
    localparam int CELLS       = COLS * ROWS;
    localparam int SETTLE_CYC  = 20;
    localparam int RANDOM_BEAT = 900;
    localparam int PRINT_LIMIT = 100;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_ready;
    tcw_pkg::tcw_req_t req;
    logic              rsp_valid;
    logic              rsp_ready;
    tcw_pkg::tcw_rsp_t rsp;

    logic [15:0]       screen_mem [0:CELLS-1];
    int unsigned       cursor_pos;
    int unsigned       hw_cursor_pos;
    tcw_pkg::tcw_rsp_t awaited_rsp_q [$];
    int                error_count;
    int                rsp_count;
    bit                send_steady;
    bit                take_steady;

    text_console_writer #(.COLUMNS(COLS), .ROWS(ROWS)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic bit scroll_screen();
        if (cursor_pos < CELLS)
            return 1'b0;
        cursor_pos -= COLS;
        for (int i = 0; i < CELLS - COLS; i++)
            screen_mem[i] = screen_mem[i + COLS];
        for (int i = CELLS - COLS; i < CELLS; i++)
            screen_mem[i] = {tcw_pkg::ATTR_DEFAULT, tcw_pkg::CHAR_SPACE};
        return 1'b1;
    endfunction

    function automatic tcw_pkg::tcw_rsp_t console_step(tcw_pkg::tcw_req_t b);
        tcw_pkg::tcw_rsp_t o;
        int unsigned       col;
        o = '0;
        if (b.opcode == tcw_pkg::OP_PUT)
        begin
            if (b.begin_line)
            begin
                col = cursor_pos % COLS;
                if (col != 0)
                    cursor_pos += COLS - col;
            end
            if (b.char_code == tcw_pkg::CHAR_NEWLINE)
            begin
                cursor_pos += COLS - cursor_pos % COLS;
                o.scrolled = scroll_screen();
            end
            else if (b.char_code != tcw_pkg::CHAR_NUL)
            begin
                o.scrolled = scroll_screen();
                if (cursor_pos < CELLS)
                begin
                    screen_mem[cursor_pos] = {tcw_pkg::ATTR_DEFAULT, b.char_code};
                    cursor_pos++;
                end
            end
        end
        else if (b.cell_index < CELLS)
        begin
            o.read_char = screen_mem[b.cell_index][7:0];
            o.read_attr = screen_mem[b.cell_index][15:8];
        end
        if (b.end_of_string)
            hw_cursor_pos = cursor_pos;
        o.cursor_cell = cursor_pos[tcw_pkg::CURSOR_W-1:0];
        o.hw_cursor   = hw_cursor_pos[tcw_pkg::CURSOR_W-1:0];
        return o;
    endfunction

    function automatic int draw_gap(bit steady);
        return steady ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(33, 126));
    endfunction

    function automatic tcw_pkg::tcw_req_t put_beat(logic [7:0] ch, bit bl, bit eos);
        tcw_pkg::tcw_req_t b;
        b.opcode        = tcw_pkg::OP_PUT;
        b.char_code     = ch;
        b.begin_line    = bl;
        b.end_of_string = eos;
        b.cell_index    = tcw_pkg::CELL_IDX_W'($urandom_range(0, 2047));
        return b;
    endfunction

    function automatic tcw_pkg::tcw_req_t read_beat(int idx, bit eos);
        tcw_pkg::tcw_req_t b;
        b.opcode        = tcw_pkg::OP_READ;
        b.char_code     = 8'($urandom_range(0, 255));
        b.begin_line    = 1'($urandom_range(0, 1));
        b.end_of_string = eos;
        b.cell_index    = tcw_pkg::CELL_IDX_W'(idx);
        return b;
    endfunction

    task automatic report_mismatch(string field, int got, int exp);
        if (error_count < PRINT_LIMIT)
            $display("beat %0d: %s is %0d, expected %0d", rsp_count, field, got, exp);
        error_count++;
    endtask

    task automatic check_rsp(tcw_pkg::tcw_rsp_t got);
        tcw_pkg::tcw_rsp_t exp;
        if (awaited_rsp_q.size() == 0)
        begin
            report_mismatch("unexpected response, cursor_cell", int'(got.cursor_cell), -1);
            return;
        end
        exp = awaited_rsp_q.pop_front();
        if (got.cursor_cell !== exp.cursor_cell)
            report_mismatch("cursor_cell", int'(got.cursor_cell), int'(exp.cursor_cell));
        if (got.hw_cursor !== exp.hw_cursor)
            report_mismatch("hw_cursor", int'(got.hw_cursor), int'(exp.hw_cursor));
        if (got.scrolled !== exp.scrolled)
            report_mismatch("scrolled", int'(got.scrolled), int'(exp.scrolled));
        if (got.read_char !== exp.read_char)
            report_mismatch("read_char", int'(got.read_char), int'(exp.read_char));
        if (got.read_attr !== exp.read_attr)
            report_mismatch("read_attr", int'(got.read_attr), int'(exp.read_attr));
    endtask

    task automatic send_beat(tcw_pkg::tcw_req_t b);
        int gap;
        gap = draw_gap(send_steady);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= b;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        awaited_rsp_q.push_back(console_step(b));
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (awaited_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_power_on_reads();
        send_beat(read_beat(0, 1'b0));
        send_beat(read_beat(CELLS - 1, 1'b0));
        send_beat(read_beat(CELLS, 1'b0));
        send_beat(read_beat(2047, 1'b1));
        send_beat(read_beat(1365, 1'b0));
        send_beat(read_beat(682, 1'b0));
    endtask

    task automatic test_put_cases();
        send_beat(put_beat(8'd65, 1'b0, 1'b0));
        send_beat(put_beat(8'd255, 1'b0, 1'b1));
        send_beat(put_beat(8'd1, 1'b0, 1'b0));
        send_beat(put_beat(tcw_pkg::CHAR_NUL, 1'b0, 1'b0));
        send_beat(put_beat(tcw_pkg::CHAR_NUL, 1'b1, 1'b1));
        send_beat(put_beat(8'd66, 1'b1, 1'b0));
        send_beat(put_beat(tcw_pkg::CHAR_NEWLINE, 1'b0, 1'b0));
        send_beat(put_beat(8'd67, 1'b1, 1'b0));
        send_beat(put_beat(tcw_pkg::CHAR_NEWLINE, 1'b1, 1'b1));
        send_beat(put_beat(8'd128, 1'b0, 1'b0));
        send_beat(read_beat(0, 1'b0));
        send_beat(read_beat(1, 1'b0));
        send_beat(read_beat(2, 1'b1));
        send_beat(read_beat(COLS, 1'b0));
    endtask

    task automatic test_screen_wrap();
        send_steady = 1'b1;
        take_steady = 1'b1;
        while (cursor_pos / COLS < ROWS - 1)
            send_beat(put_beat(tcw_pkg::CHAR_NEWLINE, 1'b0, 1'b0));
        while (cursor_pos < CELLS)
            send_beat(put_beat(printable(), 1'b0, 1'b0));
        send_beat(read_beat(CELLS - 1, 1'b1));
        send_beat(put_beat(tcw_pkg::CHAR_NUL, 1'b1, 1'b0));
        send_beat(put_beat(tcw_pkg::CHAR_NEWLINE, 1'b0, 1'b1));
        send_beat(put_beat(printable(), 1'b0, 1'b0));
        send_beat(put_beat(printable(), 1'b1, 1'b0));
        send_beat(read_beat(CELLS - 2 * COLS, 1'b0));
        send_beat(put_beat(tcw_pkg::CHAR_NEWLINE, 1'b1, 1'b1));
        send_steady = 1'b0;
        take_steady = 1'b0;
    endtask

    task automatic test_random_text();
        int          pick;
        int unsigned top;
        int          sent;
        int          mark;
        bit          drained;
        sent    = 0;
        mark    = 0;
        drained = 1'b0;
        while (sent < RANDOM_BEAT)
        begin
            if (sent >= mark)
            begin
                mark        = sent + 64;
                send_steady = ($urandom_range(0, 3) == 0);
                take_steady = ($urandom_range(0, 3) == 0);
            end
            if (!drained && sent >= RANDOM_BEAT / 2)
            begin
                wait_drained();
                drained = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_beat(put_beat(printable(), $urandom_range(0, 19) == 0,
                                   $urandom_range(0, 6) == 0));
            else if (pick < 65)
                send_beat(put_beat(tcw_pkg::CHAR_NEWLINE, 1'($urandom_range(0, 1)),
                                   $urandom_range(0, 3) == 0));
            else if (pick < 72)
                send_beat(put_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1))));
            else if (pick < 75)
                send_beat(put_beat(tcw_pkg::CHAR_NUL, 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1))));
            else if (pick < 77)
            begin
                send_beat(put_beat(printable(), 1'b0, 1'b0));
                while (cursor_pos % COLS != 0)
                begin
                    send_beat(put_beat(printable(), 1'b0, 1'b0));
                    sent++;
                end
            end
            else if (pick < 88)
                send_beat(read_beat($urandom_range(0, 2047), $urandom_range(0, 6) == 0));
            else
            begin
                top = (cursor_pos == 0) ? 0 : cursor_pos - 1;
                send_beat(read_beat($urandom_range(0, top), $urandom_range(0, 6) == 0));
            end
            sent++;
        end
    endtask

    initial
    begin : rsp_checker
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_gap(take_steady);
            if (stall != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
            check_rsp(rsp);
            rsp_count++;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        rsp_ready     = 1'b0;
        error_count   = 0;
        rsp_count     = 0;
        send_steady   = 1'b0;
        take_steady   = 1'b0;
        cursor_pos    = 0;
        hw_cursor_pos = 0;
        for (int i = 0; i < CELLS; i++)
            screen_mem[i] = {tcw_pkg::ATTR_DEFAULT, tcw_pkg::CHAR_SPACE};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on_reads();
        test_put_cases();
        test_screen_wrap();
        test_random_text();

        wait_drained();
        repeat (SETTLE_CYC) @(posedge clk);
        if (error_count == 0 && awaited_rsp_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
rtl/tcw_pkg.sv
rtl/tcw_ctrl.sv
rtl/tcw_dp.sv
rtl/text_console_writer.sv
dv/tb_top.sv
